// File: sv/tcc_pkg.sv
// tcc_pkg: shared widths, angle constants, stage types and cordic helper functions
// for the tilt compensated compass core; depends on nothing
`default_nettype none

package tcc_pkg;

   localparam int IN_W          = 16;
   localparam int OUT_W         = 16;
   localparam int SAMPLE_BITS   = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int STAGES        = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
   localparam int ATAN_IDX_W    = 5;

   // angles are q3.30, sine and cosine q2.30
   localparam int ANG_W     = 34;
   localparam int RW        = 33;
   localparam int VEC_W     = 50;
   localparam int CW        = 45;
   localparam int PROD_W    = SAMPLE_BITS + RW;
   localparam int MUL2_W    = 2 * RW;
   localparam int NORM_MSB  = 40;
   localparam int SHAMT_W   = 6;
   localparam int Q30_SHIFT = 30;
   localparam int OUT_SHIFT = 17;

   localparam logic signed [ANG_W-1:0] ANG_PI      = 34'sd3373259426;
   localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 34'sd1686629713;
   localparam logic signed [RW-1:0]    GAIN_INV    = 33'sd652032874;
   localparam logic signed [OUT_W-1:0] OUT_LIMIT   = 16'sd25736;
   localparam logic signed [ANG_W:0]   ROUND_OUT   = 35'sd65536;

   localparam logic signed [ANG_W-1:0] ATAN_TAB [32] = '{
      34'sh03243F6A8, 34'sh01DAC6705, 34'sh00FADBAFC, 34'sh007F56EA6,
      34'sh003FEAB76, 34'sh001FFD55B, 34'sh000FFFAAA, 34'sh0007FFF55,
      34'sh0003FFFEA, 34'sh0001FFFFD, 34'sh0000FFFFF, 34'sh00007FFFF,
      34'sh00003FFFF, 34'sh00001FFFF, 34'sh00000FFFF, 34'sh000007FFF,
      34'sh000003FFF, 34'sh000001FFF, 34'sh000000FFF, 34'sh0000007FF,
      34'sh0000003FF, 34'sh0000001FF, 34'sh0000000FF, 34'sh00000007F,
      34'sh00000003F, 34'sh00000001F, 34'sh00000000F, 34'sh000000008,
      34'sh000000004, 34'sh000000002, 34'sh000000001, 34'sh000000000
   };

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] ax;
      logic signed [SAMPLE_BITS-1:0] ay;
      logic signed [SAMPLE_BITS-1:0] az;
      logic signed [SAMPLE_BITS-1:0] mx;
      logic signed [SAMPLE_BITS-1:0] my;
      logic signed [SAMPLE_BITS-1:0] mz;
   } acc_side_type;

   typedef struct packed {
      acc_side_type            acc;
      logic signed [ANG_W-1:0] roll;
   } rsc_side_type;

   typedef struct packed {
      logic signed [ANG_W-1:0]       roll;
      logic signed [RW-1:0]          sr;
      logic signed [RW-1:0]          cr;
      logic signed [SAMPLE_BITS-1:0] mx;
      logic signed [SAMPLE_BITS-1:0] my;
      logic signed [SAMPLE_BITS-1:0] mz;
   } pat_side_type;

   typedef struct packed {
      logic signed [ANG_W-1:0] pitch;
      pat_side_type            pat;
   } psc_side_type;

   typedef struct packed {
      logic signed [ANG_W-1:0] pitch;
      logic signed [ANG_W-1:0] roll;
   } hat_side_type;

   localparam int SIDE_W = $bits(psc_side_type);

   typedef struct packed {
      logic signed [CW-1:0]    x;
      logic signed [CW-1:0]    y;
      logic signed [ANG_W-1:0] z;
      logic                    zero;
      logic [SIDE_W-1:0]       side;
   } vec_stage_type;

   typedef struct packed {
      logic signed [RW-1:0]    x;
      logic signed [RW-1:0]    y;
      logic signed [ANG_W-1:0] a;
      logic                    neg;
      logic [SIDE_W-1:0]       side;
   } rot_stage_type;

   function automatic logic signed [VEC_W-1:0] sext_sample(input logic [SAMPLE_BITS-1:0] s);
      return {{(VEC_W-SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
   endfunction

   function automatic logic [SHAMT_W-1:0] msb_index(input logic [VEC_W-1:0] v);
      logic [SHAMT_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < VEC_W; i++) begin
         if (v[i]) idx = SHAMT_W'(i);
      end
      return idx;
   endfunction

   // vectoring micro-rotation: drive y toward zero
   function automatic vec_stage_type vec_micro(input vec_stage_type s,
                                               input logic [ATAN_IDX_W-1:0] i);
      vec_stage_type        r;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      r = s;
      x = s.x;
      y = s.y;
      if (!y[CW-1]) begin
         r.x = x + (y >>> i);
         r.y = y - (x >>> i);
         r.z = s.z + ATAN_TAB[i];
      end else begin
         r.x = x - (y >>> i);
         r.y = y + (x >>> i);
         r.z = s.z - ATAN_TAB[i];
      end
      return r;
   endfunction

   // rotation micro-rotation: drive residual angle toward zero
   function automatic rot_stage_type rot_micro(input rot_stage_type s,
                                               input logic [ATAN_IDX_W-1:0] i);
      rot_stage_type        r;
      logic signed [RW-1:0] x;
      logic signed [RW-1:0] y;
      r = s;
      x = s.x;
      y = s.y;
      if (!s.a[ANG_W-1]) begin
         r.x = x - (y >>> i);
         r.y = y + (x >>> i);
         r.a = s.a - ATAN_TAB[i];
      end else begin
         r.x = x + (y >>> i);
         r.y = y - (x >>> i);
         r.a = s.a + ATAN_TAB[i];
      end
      return r;
   endfunction

   // fold angles past +-pi/2 by pi, results negated at the end
   function automatic rot_stage_type rot_fold(input logic signed [ANG_W-1:0] a,
                                              input logic [SIDE_W-1:0] side);
      rot_stage_type r;
      r.x    = GAIN_INV;
      r.y    = '0;
      r.side = side;
      r.a    = a;
      r.neg  = 1'b0;
      if (a > ANG_HALF_PI) begin
         r.a   = a - ANG_PI;
         r.neg = 1'b1;
      end else if (a < -ANG_HALF_PI) begin
         r.a   = a + ANG_PI;
         r.neg = 1'b1;
      end
      return r;
   endfunction

   // q3.30 to q2.13, round half up, saturate
   function automatic logic signed [OUT_W-1:0] to_out(input logic signed [ANG_W-1:0] a);
      logic signed [ANG_W:0] sum;
      logic signed [ANG_W:0] q;
      sum = (ANG_W+1)'(a) + ROUND_OUT;
      q   = sum >>> OUT_SHIFT;
      if (q > (ANG_W+1)'(OUT_LIMIT)) return OUT_LIMIT;
      if (q < -((ANG_W+1)'(OUT_LIMIT))) return -OUT_LIMIT;
      return q[OUT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: sv/tcc_atan2_pipe.sv
// tcc_atan2_pipe: pipelined vectoring cordic atan2(y, x) with a sideband carried along
// depends on tcc_pkg
`default_nettype none

module tcc_atan2_pipe
   import tcc_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire logic                    in_valid,
   input  wire logic signed [VEC_W-1:0] in_y,
   input  wire logic signed [VEC_W-1:0] in_x,
   input  wire logic [SIDE_W-1:0]       in_side,
   output logic                         out_valid,
   output logic signed [ANG_W-1:0]      out_angle,
   output logic [SIDE_W-1:0]            out_side
);

   // stage v0: half-plane fold
   logic                    v0_valid_ff;
   logic signed [VEC_W-1:0] x0_ff, x0_in, y0_ff, y0_in;
   logic signed [ANG_W-1:0] z0_ff, z0_in;
   logic                    zero0_ff, zero0_in;
   logic [SIDE_W-1:0]       side0_ff;

   // stage v1: magnitude
   logic                    v1_valid_ff;
   logic signed [VEC_W-1:0] x1_ff, y1_ff;
   logic signed [ANG_W-1:0] z1_ff;
   logic                    zero1_ff;
   logic [VEC_W-1:0]        m1_ff, m1_in;
   logic [SIDE_W-1:0]       side1_ff;

   // stage v2: normalizing shift amount
   logic                    v2_valid_ff;
   logic signed [VEC_W-1:0] x2_ff, y2_ff;
   logic signed [ANG_W-1:0] z2_ff;
   logic                    zero2_ff;
   logic                    right2_ff, right2_in;
   logic [SHAMT_W-1:0]      amt2_ff, amt2_in, msb2;
   logic [SIDE_W-1:0]       side2_ff;

   // cordic stages
   logic [STAGES:0]         valid_ff;
   vec_stage_type           stage_ff [STAGES+1];
   vec_stage_type           stage_in [STAGES+1];

   logic signed [VEC_W-1:0] ay1;
   logic signed [VEC_W-1:0] xs2, ys2;

   always_comb begin
      zero0_in = (in_x == '0) && (in_y == '0);
      if (in_x[VEC_W-1]) begin
         x0_in = -in_x;
         y0_in = -in_y;
         z0_in = in_y[VEC_W-1] ? -ANG_PI : ANG_PI;
      end else begin
         x0_in = in_x;
         y0_in = in_y;
         z0_in = '0;
      end
   end

   always_comb begin
      ay1   = y0_ff[VEC_W-1] ? -y0_ff : y0_ff;
      m1_in = (x0_ff > ay1) ? x0_ff : ay1;
   end

   always_comb begin
      msb2      = msb_index(m1_ff);
      right2_in = msb2 > SHAMT_W'(NORM_MSB);
      amt2_in   = right2_in ? msb2 - SHAMT_W'(NORM_MSB) : SHAMT_W'(NORM_MSB) - msb2;
   end

   // bring max(|x|,|y|) into [2^40, 2^41)
   always_comb begin
      xs2 = right2_ff ? (x2_ff >>> amt2_ff) : (x2_ff <<< amt2_ff);
      ys2 = right2_ff ? (y2_ff >>> amt2_ff) : (y2_ff <<< amt2_ff);
   end

   assign stage_in[0] = '{x: CW'(xs2), y: CW'(ys2), z: z2_ff, zero: zero2_ff,
                          side: side2_ff};

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      assign stage_in[k+1] = vec_micro(stage_ff[k], ATAN_IDX_W'(k));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_valid_ff <= 1'b0;
         v1_valid_ff <= 1'b0;
         v2_valid_ff <= 1'b0;
         valid_ff    <= '0;
      end else if (advance) begin
         v0_valid_ff <= in_valid;
         v1_valid_ff <= v0_valid_ff;
         v2_valid_ff <= v1_valid_ff;
         valid_ff    <= {valid_ff[STAGES-1:0], v2_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x0_ff     <= x0_in;
         y0_ff     <= y0_in;
         z0_ff     <= z0_in;
         zero0_ff  <= zero0_in;
         side0_ff  <= in_side;
         x1_ff     <= x0_ff;
         y1_ff     <= y0_ff;
         z1_ff     <= z0_ff;
         zero1_ff  <= zero0_ff;
         m1_ff     <= m1_in;
         side1_ff  <= side0_ff;
         x2_ff     <= x1_ff;
         y2_ff     <= y1_ff;
         z2_ff     <= z1_ff;
         zero2_ff  <= zero1_ff;
         right2_ff <= right2_in;
         amt2_ff   <= amt2_in;
         side2_ff  <= side1_ff;
         for (int k = 0; k <= STAGES; k++) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign out_valid = valid_ff[STAGES];
   assign out_angle = stage_ff[STAGES].zero ? '0 : stage_ff[STAGES].z;
   assign out_side  = stage_ff[STAGES].side;

`ifndef SYNTHESIS
   a_fold_right_half: assert property (@(posedge clock) disable iff (reset)
      v0_valid_ff |-> !x0_ff[VEC_W-1])
      else $error("x still negative after half-plane fold");

   a_shift_bounded: assert property (@(posedge clock) disable iff (reset)
      v2_valid_ff && !zero2_ff |-> amt2_ff <= SHAMT_W'(NORM_MSB))
      else $error("normalizing shift out of range");

   a_norm_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] && !stage_ff[0].zero |-> stage_ff[0].x[CW-1:NORM_MSB+1] == '0)
      else $error("normalized x exceeds 2^41");
`endif

endmodule

`default_nettype wire

// File: sv/tilt_compensated_compass_core.sv
// tilt_compensated_compass_core: heading, pitch and roll from accel and magnetometer samples
// depends on tcc_pkg and tcc_atan2_pipe
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_accel_x/y/z, req_magnet_x/y/z
//   rsp      out        rsp_valid/rsp_stall  rsp_heading_angle, rsp_pitch_angle, rsp_roll_angle
//
// one transaction accepted per cycle while req_stall is low; three vectoring and two rotation
// cordic chains, one micro-rotation per stage.
// reset is synchronous and clears only valid bits.
// a stalled result freezes the whole pipeline; req_stall follows from the output register.
`default_nettype none

module tilt_compensated_compass_core
   import tcc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic signed [IN_W-1:0] req_accel_x,
   input  wire logic signed [IN_W-1:0] req_accel_y,
   input  wire logic signed [IN_W-1:0] req_accel_z,
   input  wire logic signed [IN_W-1:0] req_magnet_x,
   input  wire logic signed [IN_W-1:0] req_magnet_y,
   input  wire logic signed [IN_W-1:0] req_magnet_z,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic signed [OUT_W-1:0]     rsp_heading_angle,
   output logic signed [OUT_W-1:0]     rsp_pitch_angle,
   output logic signed [OUT_W-1:0]     rsp_roll_angle
);

   localparam logic signed [MUL2_W-1:0] Q30_HALF = MUL2_W'(1) <<< (Q30_SHIFT - 1);

   logic advance;

   // roll atan2
   acc_side_type            acc_side;
   logic                    ra_valid;
   logic signed [ANG_W-1:0] roll_ang;
   logic [SIDE_W-1:0]       ra_side;

   // roll sin/cos
   rsc_side_type            rsc_in;
   logic [STAGES:0]         rr_valid_ff;
   rot_stage_type           rr_ff [STAGES+1];
   rot_stage_type           rr_in [STAGES+1];
   logic                    rs_valid_ff;
   logic signed [RW-1:0]    rs_sin_ff, rs_sin_in, rs_cos_ff, rs_cos_in;
   logic [SIDE_W-1:0]       rs_side_ff;
   rsc_side_type            rs_side;

   // pitch denominator
   logic                     d0_valid_ff;
   logic signed [PROD_W-1:0] d0_p1_ff, d0_p1_in, d0_p2_ff, d0_p2_in;
   logic signed [RW-1:0]     d0_sin_ff, d0_cos_ff;
   rsc_side_type             d0_side_ff;
   logic                     d1_valid_ff;
   logic signed [VEC_W-1:0]  d1_num_ff, d1_num_in, d1_den_ff, d1_den_in;
   pat_side_type             d1_side_ff, d1_side_in;

   // pitch atan2
   logic                    pa_valid;
   logic signed [ANG_W-1:0] pitch_ang;
   logic [SIDE_W-1:0]       pa_side;
   psc_side_type            psc_in;

   // pitch sin/cos
   logic [STAGES:0]         pr_valid_ff;
   rot_stage_type           pr_ff [STAGES+1];
   rot_stage_type           pr_in [STAGES+1];
   logic                    ps_valid_ff;
   logic signed [RW-1:0]    ps_sin_ff, ps_sin_in, ps_cos_ff, ps_cos_in;
   logic [SIDE_W-1:0]       ps_side_ff;
   psc_side_type            ps_side;

   // magnetometer rotation
   logic                          p0_valid_ff;
   logic signed [MUL2_W-1:0]      p0_spsr_ff, p0_spsr_in, p0_spcr_ff, p0_spcr_in;
   logic signed [PROD_W-1:0]      p0_cpmx_ff, p0_cpmx_in, p0_crmy_ff, p0_crmy_in;
   logic signed [PROD_W-1:0]      p0_srmz_ff, p0_srmz_in;
   logic signed [SAMPLE_BITS-1:0] p0_my_ff, p0_mz_ff;
   hat_side_type                  p0_side_ff;
   logic                          p1_valid_ff;
   logic signed [RW-1:0]          p1_spsr_ff, p1_spsr_in, p1_spcr_ff, p1_spcr_in;
   logic signed [PROD_W-1:0]      p1_cpmx_ff;
   logic signed [VEC_W-1:0]       p1_hy_ff, p1_hy_in;
   logic signed [SAMPLE_BITS-1:0] p1_my_ff, p1_mz_ff;
   hat_side_type                  p1_side_ff;
   logic                          p2_valid_ff;
   logic signed [PROD_W-1:0]      p2_t1_ff, p2_t1_in, p2_t2_ff, p2_t2_in, p2_cpmx_ff;
   logic signed [VEC_W-1:0]       p2_hy_ff;
   hat_side_type                  p2_side_ff;
   logic                          p3_valid_ff;
   logic signed [VEC_W-1:0]       p3_hx_ff, p3_hx_in, p3_nhy_ff, p3_nhy_in;
   hat_side_type                  p3_side_ff;

   // heading atan2 and output
   logic                    ha_valid;
   logic signed [ANG_W-1:0] head_ang;
   logic [SIDE_W-1:0]       ha_side;
   hat_side_type            hat;
   logic                    rsp_valid_ff;
   logic signed [OUT_W-1:0] rsp_heading_ff, rsp_pitch_ff, rsp_roll_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // ---------------- roll = atan2(ay, az)
   always_comb begin
      acc_side.ax = req_accel_x[SAMPLE_BITS-1:0];
      acc_side.ay = req_accel_y[SAMPLE_BITS-1:0];
      acc_side.az = req_accel_z[SAMPLE_BITS-1:0];
      acc_side.mx = req_magnet_x[SAMPLE_BITS-1:0];
      acc_side.my = req_magnet_y[SAMPLE_BITS-1:0];
      acc_side.mz = req_magnet_z[SAMPLE_BITS-1:0];
   end

   tcc_atan2_pipe u_roll_atan (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_y      (sext_sample(req_accel_y[SAMPLE_BITS-1:0])),
      .in_x      (sext_sample(req_accel_z[SAMPLE_BITS-1:0])),
      .in_side   (SIDE_W'(acc_side)),
      .out_valid (ra_valid),
      .out_angle (roll_ang),
      .out_side  (ra_side)
   );

   // ---------------- sin/cos of roll
   always_comb begin
      rsc_in.acc  = acc_side_type'(ra_side[$bits(acc_side_type)-1:0]);
      rsc_in.roll = roll_ang;
   end

   assign rr_in[0] = rot_fold(roll_ang, SIDE_W'(rsc_in));

   for (genvar k = 0; k < STAGES; k++) begin : g_roll_rot
      assign rr_in[k+1] = rot_micro(rr_ff[k], ATAN_IDX_W'(k));
   end

   assign rs_sin_in = rr_ff[STAGES].neg ? -rr_ff[STAGES].y : rr_ff[STAGES].y;
   assign rs_cos_in = rr_ff[STAGES].neg ? -rr_ff[STAGES].x : rr_ff[STAGES].x;
   assign rs_side   = rsc_side_type'(rs_side_ff[$bits(rsc_side_type)-1:0]);

   // ---------------- den = ay*sin(roll) + az*cos(roll), numerator -ax * 2^30
   assign d0_p1_in = PROD_W'(rs_side.acc.ay) * PROD_W'(rs_sin_ff);
   assign d0_p2_in = PROD_W'(rs_side.acc.az) * PROD_W'(rs_cos_ff);

   always_comb begin
      d1_den_in       = VEC_W'(d0_p1_ff + d0_p2_ff);
      d1_num_in       = (-sext_sample(d0_side_ff.acc.ax)) <<< Q30_SHIFT;
      d1_side_in.roll = d0_side_ff.roll;
      d1_side_in.sr   = d0_sin_ff;
      d1_side_in.cr   = d0_cos_ff;
      d1_side_in.mx   = d0_side_ff.acc.mx;
      d1_side_in.my   = d0_side_ff.acc.my;
      d1_side_in.mz   = d0_side_ff.acc.mz;
   end

   tcc_atan2_pipe u_pitch_atan (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (d1_valid_ff),
      .in_y      (d1_num_ff),
      .in_x      (d1_den_ff),
      .in_side   (SIDE_W'(d1_side_ff)),
      .out_valid (pa_valid),
      .out_angle (pitch_ang),
      .out_side  (pa_side)
   );

   // ---------------- sin/cos of pitch
   always_comb begin
      psc_in.pitch = pitch_ang;
      psc_in.pat   = pat_side_type'(pa_side[$bits(pat_side_type)-1:0]);
   end

   assign pr_in[0] = rot_fold(pitch_ang, SIDE_W'(psc_in));

   for (genvar k = 0; k < STAGES; k++) begin : g_pitch_rot
      assign pr_in[k+1] = rot_micro(pr_ff[k], ATAN_IDX_W'(k));
   end

   assign ps_sin_in = pr_ff[STAGES].neg ? -pr_ff[STAGES].y : pr_ff[STAGES].y;
   assign ps_cos_in = pr_ff[STAGES].neg ? -pr_ff[STAGES].x : pr_ff[STAGES].x;
   assign ps_side   = psc_side_type'(ps_side_ff[$bits(psc_side_type)-1:0]);

   // ---------------- tilt compensated magnetometer vector
   always_comb begin
      p0_spsr_in = MUL2_W'(ps_sin_ff) * MUL2_W'(ps_side.pat.sr);
      p0_spcr_in = MUL2_W'(ps_sin_ff) * MUL2_W'(ps_side.pat.cr);
      p0_cpmx_in = PROD_W'(ps_cos_ff) * PROD_W'(ps_side.pat.mx);
      p0_crmy_in = PROD_W'(ps_side.pat.cr) * PROD_W'(ps_side.pat.my);
      p0_srmz_in = PROD_W'(ps_side.pat.sr) * PROD_W'(ps_side.pat.mz);
   end

   // round the q.60 products back to q.30
   assign p1_spsr_in = RW'((p0_spsr_ff + Q30_HALF) >>> Q30_SHIFT);
   assign p1_spcr_in = RW'((p0_spcr_ff + Q30_HALF) >>> Q30_SHIFT);
   assign p1_hy_in   = VEC_W'(p0_crmy_ff) - VEC_W'(p0_srmz_ff);

   assign p2_t1_in = PROD_W'(p1_spsr_ff) * PROD_W'(p1_my_ff);
   assign p2_t2_in = PROD_W'(p1_spcr_ff) * PROD_W'(p1_mz_ff);

   assign p3_hx_in  = VEC_W'(p2_cpmx_ff + p2_t1_ff + p2_t2_ff);
   assign p3_nhy_in = -p2_hy_ff;

   tcc_atan2_pipe u_head_atan (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (p3_valid_ff),
      .in_y      (p3_nhy_ff),
      .in_x      (p3_hx_ff),
      .in_side   (SIDE_W'(p3_side_ff)),
      .out_valid (ha_valid),
      .out_angle (head_ang),
      .out_side  (ha_side)
   );

   assign hat = hat_side_type'(ha_side[$bits(hat_side_type)-1:0]);

   // ---------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rr_valid_ff  <= '0;
         rs_valid_ff  <= 1'b0;
         d0_valid_ff  <= 1'b0;
         d1_valid_ff  <= 1'b0;
         pr_valid_ff  <= '0;
         ps_valid_ff  <= 1'b0;
         p0_valid_ff  <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rr_valid_ff  <= {rr_valid_ff[STAGES-1:0], ra_valid};
         rs_valid_ff  <= rr_valid_ff[STAGES];
         d0_valid_ff  <= rs_valid_ff;
         d1_valid_ff  <= d0_valid_ff;
         pr_valid_ff  <= {pr_valid_ff[STAGES-1:0], pa_valid};
         ps_valid_ff  <= pr_valid_ff[STAGES];
         p0_valid_ff  <= ps_valid_ff;
         p1_valid_ff  <= p0_valid_ff;
         p2_valid_ff  <= p1_valid_ff;
         p3_valid_ff  <= p2_valid_ff;
         rsp_valid_ff <= ha_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k <= STAGES; k++) begin
            rr_ff[k] <= rr_in[k];
            pr_ff[k] <= pr_in[k];
         end
         rs_sin_ff      <= rs_sin_in;
         rs_cos_ff      <= rs_cos_in;
         rs_side_ff     <= rr_ff[STAGES].side;
         d0_p1_ff       <= d0_p1_in;
         d0_p2_ff       <= d0_p2_in;
         d0_sin_ff      <= rs_sin_ff;
         d0_cos_ff      <= rs_cos_ff;
         d0_side_ff     <= rs_side;
         d1_num_ff      <= d1_num_in;
         d1_den_ff      <= d1_den_in;
         d1_side_ff     <= d1_side_in;
         ps_sin_ff      <= ps_sin_in;
         ps_cos_ff      <= ps_cos_in;
         ps_side_ff     <= pr_ff[STAGES].side;
         p0_spsr_ff     <= p0_spsr_in;
         p0_spcr_ff     <= p0_spcr_in;
         p0_cpmx_ff     <= p0_cpmx_in;
         p0_crmy_ff     <= p0_crmy_in;
         p0_srmz_ff     <= p0_srmz_in;
         p0_my_ff       <= ps_side.pat.my;
         p0_mz_ff       <= ps_side.pat.mz;
         p0_side_ff     <= '{pitch: ps_side.pitch, roll: ps_side.pat.roll};
         p1_spsr_ff     <= p1_spsr_in;
         p1_spcr_ff     <= p1_spcr_in;
         p1_cpmx_ff     <= p0_cpmx_ff;
         p1_hy_ff       <= p1_hy_in;
         p1_my_ff       <= p0_my_ff;
         p1_mz_ff       <= p0_mz_ff;
         p1_side_ff     <= p0_side_ff;
         p2_t1_ff       <= p2_t1_in;
         p2_t2_ff       <= p2_t2_in;
         p2_cpmx_ff     <= p1_cpmx_ff;
         p2_hy_ff       <= p1_hy_ff;
         p2_side_ff     <= p1_side_ff;
         p3_hx_ff       <= p3_hx_in;
         p3_nhy_ff      <= p3_nhy_in;
         p3_side_ff     <= p2_side_ff;
         rsp_heading_ff <= to_out(head_ang);
         rsp_pitch_ff   <= to_out(hat.pitch);
         rsp_roll_ff    <= to_out(hat.roll);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_heading_angle = rsp_heading_ff;
   assign rsp_pitch_angle   = rsp_pitch_ff;
   assign rsp_roll_angle    = rsp_roll_ff;

`ifndef SYNTHESIS
   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_heading_ff >= -OUT_LIMIT && rsp_heading_ff <= OUT_LIMIT
                    && rsp_pitch_ff >= -OUT_LIMIT && rsp_pitch_ff <= OUT_LIMIT
                    && rsp_roll_ff >= -OUT_LIMIT && rsp_roll_ff <= OUT_LIMIT)
      else $error("result angle outside saturation limit");

   a_roll_fold: assert property (@(posedge clock) disable iff (reset)
      rr_valid_ff[0] |-> rr_ff[0].a <= ANG_HALF_PI && rr_ff[0].a >= -ANG_HALF_PI)
      else $error("roll angle not folded into +-pi/2");

   a_pitch_fold: assert property (@(posedge clock) disable iff (reset)
      pr_valid_ff[0] |-> pr_ff[0].a <= ANG_HALF_PI && pr_ff[0].a >= -ANG_HALF_PI)
      else $error("pitch angle not folded into +-pi/2");
`endif

endmodule

`default_nettype wire
